// ----- rtl/mbrc_pkg.sv -----
// Shared types, codes and defaults of the monochrome rectangle copy block.
package mbrc_pkg;

    localparam int FRAME_BYTES_DEF = 65536;
    localparam logic [8:0]  BPR_RESET = 9'd80;
    localparam logic [10:0] ROWS_RESET = 11'd480;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_COPY  = 2'd2;

    localparam logic [1:0] CFG_BPR  = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] byte_address;
        logic [7:0]  write_byte;
        logic [10:0] src_x;
        logic [9:0]  src_y;
        logic [10:0] dst_x;
        logic [9:0]  dst_y;
        logic [11:0] rect_width;
        logic [10:0] rect_height;
    } t_req;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       status;
    } t_rsp;

endpackage

// ----- rtl/mbrc_frame_mem.sv -----
// Single-port frame byte memory with registered read data.
module mbrc_frame_mem #(
    parameter int FRAME_BYTES = mbrc_pkg::FRAME_BYTES_DEF,
    parameter int AW = $clog2(FRAME_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [FRAME_BYTES];

    // write or read one byte a cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end
endmodule

// ----- rtl/mono_bit_rectangle_copy_top.sv -----
// Top level: request sequencer, bounds checks and pixel copy engine.
// Byte writes and out-of-range requests answer in the next cycle; byte reads pass
// through the memory read register and S_RB. A copy checks source and destination
// bounds, then steps each pixel through address add, source multiply, source read,
// destination multiply, destination read and write back, on one shared multiplier
// and the single memory port. The result appears on o_rsp for exactly one cycle
// with o_strobe high; the receiver cannot stall it. The frame memory has no reset
// and needs no clearing pass. Write configuration only while idle.
module mono_bit_rectangle_copy_top #(
    parameter int FRAME_BYTES = mbrc_pkg::FRAME_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  mbrc_pkg::t_req i_req,
    output logic           o_strobe,
    output mbrc_pkg::t_rsp o_rsp,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [10:0]    i_cfg_data
);
    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [21:0] FB = 22'(FRAME_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_RB, S_CHK_S, S_CHK_D, S_PX, S_MS, S_RS, S_MD, S_RD, S_WR
    } t_state;

    t_state         r_state;
    logic [8:0]     r_bpr;
    logic [10:0]    r_rows;
    mbrc_pkg::t_req r_req;
    logic           r_up, r_left, r_bit;
    logic [10:0]    r_row;
    logic [11:0]    r_col;
    logic [10:0]    r_pxs, r_pxd;
    logic [9:0]     r_pys, r_pyd;
    logic [AW-1:0]  r_addr;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;

    logic [10:0] chk_x;
    logic [9:0]  chk_y;
    logic [12:0] x_end;
    logic [11:0] y_end;
    logic [11:0] mul_a;
    logic [20:0] prod;
    logic [21:0] addr_sum;
    logic        fits;
    logic [10:0] ro;
    logic [11:0] co;
    logic [7:0]  pmask;
    logic        last;

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // shared bounds check operand selection
    assign chk_x = (r_state == S_CHK_S) ? r_req.src_x : r_req.dst_x;
    assign chk_y = (r_state == S_CHK_S) ? r_req.src_y : r_req.dst_y;
    assign x_end = 13'(chk_x) + 13'(r_req.rect_width);
    assign y_end = 12'(chk_y) + 12'(r_req.rect_height);

    // shared multiplier: frame end in checks, row base in address steps
    always_comb begin
        case (r_state)
            S_MS:    mul_a = 12'(r_pys);
            S_MD:    mul_a = 12'(r_pyd);
            default: mul_a = y_end;
        endcase
    end
    assign prod = mul_a * r_bpr;
    assign addr_sum = 22'(prod) +
        ((r_state == S_MS) ? 22'(r_pxs[10:3]) : 22'(r_pxd[10:3]));

    assign fits = (x_end <= {1'b0, r_bpr, 3'b000}) && (y_end <= 12'(r_rows)) &&
                  (22'(prod) <= FB);

    // pixel order within the rectangle
    assign ro = r_up ? (r_req.rect_height - 11'd1 - r_row) : r_row;
    assign co = r_left ? (r_req.rect_width - 12'd1 - r_col) : r_col;
    assign pmask = 8'h80 >> r_pxd[2:0];
    assign last = (r_col == r_req.rect_width - 12'd1) &&
                  (r_row == r_req.rect_height - 11'd1);

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_addr;
        mem_wdata = r_bit ? (mem_rdata | pmask) : (mem_rdata & ~pmask);
        if (r_state == S_IDLE) begin
            mem_addr  = AW'(i_req.byte_address);
            mem_wdata = i_req.write_byte;
            mem_we    = i_start && (i_req.req_type == mbrc_pkg::REQ_WRITE) &&
                        (32'(i_req.byte_address) < 32'(FRAME_BYTES));
        end else if (r_state == S_WR) begin
            mem_we = 1'b1;
        end
    end

    mbrc_frame_mem #(.FRAME_BYTES(FRAME_BYTES), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // sequencer, configuration and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bpr    <= mbrc_pkg::BPR_RESET;
            r_rows   <= mbrc_pkg::ROWS_RESET;
            o_strobe <= 1'b0;
            o_rsp    <= '0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_valid) begin
                if (i_cfg_index == mbrc_pkg::CFG_BPR) r_bpr <= i_cfg_data[8:0];
                else if (i_cfg_index == mbrc_pkg::CFG_ROWS) r_rows <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req  <= i_req;
                        r_up   <= i_req.dst_y >= i_req.src_y;
                        r_left <= (i_req.dst_y == i_req.src_y) &&
                                  (i_req.dst_x > i_req.src_x) &&
                                  (13'(i_req.dst_x) <
                                   13'(i_req.src_x) + 13'(i_req.rect_width));
                        r_row  <= '0;
                        r_col  <= '0;
                        o_rsp  <= '0;
                        if ((i_req.req_type == mbrc_pkg::REQ_WRITE ||
                             i_req.req_type == mbrc_pkg::REQ_READ) &&
                            32'(i_req.byte_address) >= 32'(FRAME_BYTES)) begin
                            o_rsp.status <= 1'b1;
                            o_strobe     <= 1'b1;
                        end else if (i_req.req_type == mbrc_pkg::REQ_READ) begin
                            r_state <= S_RB;
                        end else if (i_req.req_type == mbrc_pkg::REQ_COPY &&
                                     i_req.rect_width != '0 &&
                                     i_req.rect_height != '0) begin
                            r_state <= S_CHK_S;
                        end else begin
                            o_strobe <= 1'b1;
                        end
                    end
                end
                S_RB: begin
                    o_rsp.read_byte <= mem_rdata;
                    o_strobe        <= 1'b1;
                    r_state         <= S_IDLE;
                end
                S_CHK_S: begin
                    r_bit   <= !fits;
                    r_state <= S_CHK_D;
                end
                S_CHK_D: begin
                    if (r_bit || !fits) begin
                        o_rsp.status <= 1'b1;
                        o_strobe     <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_PX;
                    end
                end
                S_PX: begin
                    r_pxs   <= 11'(12'(r_req.src_x) + co);
                    r_pxd   <= 11'(12'(r_req.dst_x) + co);
                    r_pys   <= 10'(11'(r_req.src_y) + ro);
                    r_pyd   <= 10'(11'(r_req.dst_y) + ro);
                    r_state <= S_MS;
                end
                S_MS: begin
                    r_addr  <= addr_sum[AW-1:0];
                    r_state <= S_RS;
                end
                S_RS: r_state <= S_MD;
                S_MD: begin
                    r_bit   <= mem_rdata[3'd7 - r_pxs[2:0]];
                    r_addr  <= addr_sum[AW-1:0];
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    if (last) begin
                        o_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        if (r_col == r_req.rect_width - 12'd1) begin
                            r_col <= '0;
                            r_row <= r_row + 11'd1;
                        end else begin
                            r_col <= r_col + 12'd1;
                        end
                        r_state <= S_PX;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a result leaves the block idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !o_busy) else $error("result while busy");

    // a copy never writes outside the frame rows
    a_wr_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (11'(r_pyd) < r_rows)) else $error("row out of frame");

    // an accepted request either answers at once or keeps the block busy
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_strobe || o_busy)) else $error("request lost");
endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the monochrome frame store with rectangle copy.
`timescale 1ns / 100ps

module testbench;

    localparam int MEM_BYTES  = 65536;
    localparam int STALL_LIMIT = 200000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_start;
    logic           o_busy;
    mbrc_pkg::t_req i_req;
    logic           o_strobe;
    mbrc_pkg::t_rsp o_rsp;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [1:0]     i_cfg_index;
    logic [10:0]    i_cfg_data;

    // Shadow frame, its written flags and the shadow configuration
    logic [7:0]     shadow_frame [MEM_BYTES];
    bit             byte_known   [MEM_BYTES];
    int             pitch_bytes;
    int             frame_rows;
    mbrc_pkg::t_rsp pending_rsp [$];
    int             error_count;
    int             quiet_cycles;
    bit             no_gaps;

    mono_bit_rectangle_copy_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_req      (i_req),
        .o_strobe   (o_strobe),
        .o_rsp      (o_rsp),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Pixel access on the shadow frame, most significant bit first
    function automatic bit pixel_at(int x, int y);
        int a;
        a = y * pitch_bytes + (x >> 3);
        return shadow_frame[a][7 - (x & 7)];
    endfunction

    function automatic void pixel_put(int x, int y, bit v);
        int a;
        a = y * pitch_bytes + (x >> 3);
        shadow_frame[a][7 - (x & 7)] = v;
    endfunction

    function automatic bit rect_in_frame(int x, int y, int w, int h);
        if (x + w > 8 * pitch_bytes) return 1'b0;
        if (y + h > frame_rows) return 1'b0;
        if ((y + h) * pitch_bytes > MEM_BYTES) return 1'b0;
        return 1'b1;
    endfunction

    // Apply one request to the shadow frame and return its response
    function automatic mbrc_pkg::t_rsp frame_response(mbrc_pkg::t_req r);
        mbrc_pkg::t_rsp rsp;
        int sx, sy, dx, dy, w, h, ro, co;
        bit up, leftward;
        rsp = '0;
        sx = r.src_x; sy = r.src_y; dx = r.dst_x; dy = r.dst_y;
        w = r.rect_width; h = r.rect_height;
        case (r.req_type)
            mbrc_pkg::REQ_WRITE: begin
                shadow_frame[r.byte_address] = r.write_byte;
                byte_known[r.byte_address] = 1'b1;
            end
            mbrc_pkg::REQ_READ: rsp.read_byte = shadow_frame[r.byte_address];
            mbrc_pkg::REQ_COPY: begin
                if (w != 0 && h != 0) begin
                    if (rect_in_frame(sx, sy, w, h) && rect_in_frame(dx, dy, w, h)) begin
                        // Order rows and columns so overlap acts like a snapshot
                        up = (dy >= sy);
                        leftward = (dy == sy) && (dx > sx) && (dx < sx + w);
                        for (int i = 0; i < h; i++) begin
                            ro = up ? (h - 1 - i) : i;
                            for (int j = 0; j < w; j++) begin
                                co = leftward ? (w - 1 - j) : j;
                                pixel_put(dx + co, dy + ro, pixel_at(sx + co, sy + ro));
                            end
                        end
                    end else begin
                        rsp.status = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // Compare each response with the oldest pending one
    always @(posedge i_clk) begin
        mbrc_pkg::t_rsp want;
        if (i_rst_n && o_strobe) begin
            if (pending_rsp.size() == 0) begin
                $error("response with none pending: read_byte %0h status %0b",
                       o_rsp.read_byte, o_rsp.status);
                error_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.read_byte !== want.read_byte) begin
                    $error("read_byte: expected %0h actual %0h", want.read_byte,
                           o_rsp.read_byte);
                    error_count++;
                end
                if (o_rsp.status !== want.status) begin
                    $error("status: expected %0b actual %0b", want.status, o_rsp.status);
                    error_count++;
                end
            end
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (no_gaps) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item, hold start until accepted, then idle a random gap
    task automatic send_item(mbrc_pkg::t_req r);
        int gap;
        @(negedge i_clk);
        i_req = r;
        i_start = 1'b1;
        // busy seen at the falling edge holds through the next rising edge
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_rsp.push_back(frame_response(r));
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Lower start and wait until every pending response has come
    task automatic drain();
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, int value);
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value[10:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == mbrc_pkg::CFG_BPR) pitch_bytes = value & 'h1FF;
        else if (idx == mbrc_pkg::CFG_ROWS) frame_rows = value & 'h7FF;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic mbrc_pkg::t_req noise_req();
        mbrc_pkg::t_req r;
        r.req_type = 2'($urandom_range(0, 3));
        r.byte_address = 16'($urandom);
        r.write_byte = 8'($urandom);
        r.src_x = 11'($urandom); r.src_y = 10'($urandom);
        r.dst_x = 11'($urandom); r.dst_y = 10'($urandom);
        r.rect_width = 12'($urandom_range(0, 4095));
        r.rect_height = 11'($urandom_range(0, 2047));
        return r;
    endfunction

    task automatic write_byte_at(int a, int d);
        mbrc_pkg::t_req r;
        r = noise_req();
        r.req_type = mbrc_pkg::REQ_WRITE;
        r.byte_address = 16'(a);
        r.write_byte = 8'(d);
        send_item(r);
    endtask

    task automatic read_byte_at(int a);
        mbrc_pkg::t_req r;
        r = noise_req();
        r.req_type = mbrc_pkg::REQ_READ;
        r.byte_address = 16'(a);
        if (!byte_known[a]) write_byte_at(a, $urandom);
        send_item(r);
    endtask

    // Fill every byte a rectangle touches that was never written
    task automatic fill_rect(int x, int y, int w, int h);
        int a;
        for (int row = y; row < y + h; row++)
            for (int b = x >> 3; b <= (x + w - 1) >> 3; b++) begin
                a = row * pitch_bytes + b;
                if (!byte_known[a]) write_byte_at(a, $urandom);
            end
    endtask

    task automatic copy_rect_req(int sx, int sy, int dx, int dy, int w, int h);
        mbrc_pkg::t_req r;
        r = noise_req();
        r.req_type = mbrc_pkg::REQ_COPY;
        r.src_x = 11'(sx); r.src_y = 10'(sy); r.dst_x = 11'(dx); r.dst_y = 10'(dy);
        r.rect_width = 12'(w); r.rect_height = 11'(h);
        if (w != 0 && h != 0 && rect_in_frame(sx, sy, w, h) && rect_in_frame(dx, dy, w, h))
        begin
            fill_rect(sx, sy, w, h);
            fill_rect(dx, dy, w, h);
        end
        send_item(r);
    endtask

    // Send a random item; reads and copies that land in the frame touch known bytes only
    task automatic send_noise();
        mbrc_pkg::t_req r;
        int w, h;
        r = noise_req();
        w = r.rect_width;
        h = r.rect_height;
        if (r.req_type == mbrc_pkg::REQ_READ) begin
            read_byte_at(r.byte_address);
        end else if (r.req_type == mbrc_pkg::REQ_COPY && w != 0 && h != 0 &&
                     rect_in_frame(r.src_x, r.src_y, w, h) &&
                     rect_in_frame(r.dst_x, r.dst_y, w, h)) begin
            // Shrink a copy that fits so it stays short
            copy_rect_req(r.src_x, r.src_y, r.dst_x, r.dst_y,
                          (w > 24) ? 24 : w, (h > 4) ? 4 : h);
        end else begin
            send_item(r);
        end
    endtask

    // Byte access extremes and the unused request type
    task automatic test_byte_access();
        mbrc_pkg::t_req r;
        write_byte_at(16'hFFFF, 8'hFF);
        write_byte_at(16'h0000, 8'h00);
        write_byte_at(16'h8001, 8'hA5);
        read_byte_at(16'hFFFF);
        read_byte_at(16'h0000);
        read_byte_at(16'h8001);
        r = noise_req();
        r.req_type = 2'd3;
        send_item(r);
    endtask

    // Copy directions, empty and rejected rectangles at reset settings
    task automatic test_copy_cases();
        copy_rect_req(3, 2, 5, 2, 13, 3);       // same row, overlap to the right
        copy_rect_req(9, 1, 4, 1, 20, 2);       // same row, overlap to the left
        copy_rect_req(0, 0, 2, 1, 17, 3);       // destination below, overlapping
        copy_rect_req(5, 4, 1, 2, 11, 3);       // destination above, overlapping
        copy_rect_req(7, 0, 7, 0, 9, 2);        // copy onto itself
        copy_rect_req(0, 0, 8, 3, 0, 5);        // zero width
        copy_rect_req(2047, 1023, 8, 3, 4, 0);  // zero height, nothing checked
        copy_rect_req(636, 0, 0, 0, 5, 1);      // source past the last column
        copy_rect_req(0, 0, 0, 478, 1, 3);      // destination past the last row
        copy_rect_req(2047, 1023, 2047, 1023, 2048, 1024);
        read_byte_at(1);
        read_byte_at(80);
    endtask

    // Random traffic under one setting, mostly valid small copies
    task automatic test_random_phase(int bpr, int rows, int count);
        int usable, w, h, sx, sy, dx, dy, roll, top, span;
        write_cfg(mbrc_pkg::CFG_BPR, bpr);
        write_cfg(mbrc_pkg::CFG_ROWS, rows);
        usable = (pitch_bytes == 0) ? 0 : MEM_BYTES / pitch_bytes;
        if (usable > frame_rows) usable = frame_rows;
        top = (usable > 12) ? 12 : usable;
        // Keep copies in the leftmost columns so few bytes need a first write
        span = (8 * pitch_bytes < 64) ? 8 * pitch_bytes : 64;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) drain();
            if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                if ($urandom_range(0, 3) == 0) write_byte_at($urandom_range(0, 65535), $urandom);
                else if (usable > 0)
                    write_byte_at($urandom_range(0, usable * pitch_bytes - 1), $urandom);
                else write_byte_at($urandom_range(0, 255), $urandom);
            end else if (roll < 32) begin
                if (usable > 0 && $urandom_range(0, 3) != 0)
                    read_byte_at($urandom_range(0, top * pitch_bytes - 1));
                else read_byte_at($urandom_range(0, 65535));
            end else if (roll < 42 || usable == 0) begin
                send_noise();
            end else begin
                w = $urandom_range(1, (span < 24) ? span : 24);
                h = $urandom_range(1, (top < 4) ? top : 4);
                sx = $urandom_range(0, span - w);
                sy = $urandom_range(0, top - h);
                if ($urandom_range(0, 1)) begin
                    // Neighbor of the source, shifted by at most one row and five columns
                    dy = sy + $urandom_range(0, 2) - 1;
                    dx = sx + $urandom_range(0, 10) - 5;
                    if (dy < 0 || dy > top - h) dy = sy;
                    if (dx < 0 || dx > span - w) dx = sx;
                end else begin
                    dx = $urandom_range(0, span - w);
                    dy = $urandom_range(0, top - h);
                end
                if ($urandom_range(0, 19) == 0) w = 0;
                if ($urandom_range(0, 19) == 0) dx = 8 * pitch_bytes - w + 1;
                copy_rect_req(sx, sy, dx, dy, w, h);
            end
        end
        no_gaps = 1'b0;
    endtask

    // Large copies: full pitch width, tall column, high rows and columns, one past memory
    task automatic test_large_copies();
        write_cfg(mbrc_pkg::CFG_BPR, 256);
        write_cfg(mbrc_pkg::CFG_ROWS, 1024);
        copy_rect_req(0, 0, 0, 0, 2048, 1);     // full pitch width onto itself
        copy_rect_req(1030, 2, 1500, 3, 9, 2);
        copy_rect_req(0, 250, 0, 0, 3, 7);      // last row ends past memory
        read_byte_at(256 + 150);
        write_cfg(mbrc_pkg::CFG_BPR, 1);
        copy_rect_req(1, 0, 0, 0, 1, 1024);
        copy_rect_req(0, 600, 3, 1000, 5, 3);
        read_byte_at(1001);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = mbrc_pkg::CFG_BPR;
        i_cfg_data = '0;
        error_count = 0;
        quiet_cycles = 0;
        no_gaps = 1'b0;
        pitch_bytes = mbrc_pkg::BPR_RESET;
        frame_rows = mbrc_pkg::ROWS_RESET;
        foreach (byte_known[k]) byte_known[k] = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_byte_access();
        test_copy_cases();
        test_random_phase(80, 480, 45);
        test_random_phase(2, 8, 25);
        test_random_phase(1, 1024, 35);
        test_random_phase(256, 1024, 45);
        test_random_phase(3, 5, 25);
        test_random_phase(256, 1, 25);
        test_random_phase(1, 1, 20);
        test_random_phase(0, 1024, 20);
        test_random_phase(5, 1, 25);
        test_large_copies();

        drain();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
